>>> sv/pip_pkg.sv
`default_nettype none

package pip_pkg;

   typedef enum logic [1:0] {
      LOC_OUTSIDE  = 2'd0,
      LOC_BOUNDARY = 2'd1,
      LOC_INSIDE   = 2'd2
   } location_type;

   // load strobes for the four pipeline stages of an edge unit
   typedef struct packed {
      logic ld_op;
      logic ld_diff;
      logic ld_prod;
      logic ld_flag;
   } stage_en_type;

   typedef struct packed {
      logic on_edge;
      logic crossing;
   } edge_flags_type;

   // per-request bookkeeping that travels alongside the edge pipelines
   typedef struct packed {
      logic first;
      logic last;
      logic use_a;
      logic use_b;
   } meta_type;

endpackage

`default_nettype wire

>>> sv/point_in_polygon_test_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | vertex_x, vertex_y, point_x, point_y, last_vertex
// rsp     | out       | rsp_valid/rsp_ready  | location (one per polygon, at its last vertex)
//
// One vertex per cycle sustained while no response is stalled; a response is registered
// after its last vertex passes the four-stage edge pipeline (operands, differences,
// products, flags), then the parity update into the output register.
// Synchronous active-high reset empties the pipeline and starts a new polygon.
// A stalled response holds only the final stage; earlier stages keep filling bubbles.
`default_nettype none

module point_in_polygon_test_core #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic                          req_last_vertex,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_location
);

   localparam int STAGES = 4;

   logic accept, is_first;

   logic in_polygon_ff;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] query_x_ff, query_y_ff;
   logic signed [COORD_WIDTH-1:0] qx_sel, qy_sel, close_x, close_y;

   logic [STAGES-1:0] stage_v_ff, move, ld;
   pip_pkg::meta_type meta_ff [STAGES];
   pip_pkg::meta_type meta_in;
   pip_pkg::stage_en_type en;
   pip_pkg::edge_flags_type flags_a, flags_b;

   logic parity_ff, parity_in, on_edge_ff, on_edge_in, parity_base, on_edge_base;
   logic rsp_valid_ff;
   pip_pkg::location_type location_ff, location_in;

   assign accept   = req_valid && req_ready;
   assign is_first = !in_polygon_ff;

   // first vertex uses the incoming point and closes onto itself
   assign qx_sel  = is_first ? req_point_x  : query_x_ff;
   assign qy_sel  = is_first ? req_point_y  : query_y_ff;
   assign close_x = is_first ? req_vertex_x : first_x_ff;
   assign close_y = is_first ? req_vertex_y : first_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_polygon_ff <= 1'b0;
      end else if (accept) begin
         in_polygon_ff <= !req_last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= req_vertex_x;
         prev_y_ff <= req_vertex_y;
         if (is_first) begin
            first_x_ff <= req_vertex_x;
            first_y_ff <= req_vertex_y;
            query_x_ff <= req_point_x;
            query_y_ff <= req_point_y;
         end
      end
   end

   // pipeline flow: a stage moves on when the next one is empty or moving
   always_comb begin
      move[STAGES-1] = stage_v_ff[STAGES-1] &&
                       (!meta_ff[STAGES-1].last || !rsp_valid_ff || rsp_ready);
      for (int k = STAGES - 2; k >= 0; k--) begin
         move[k] = stage_v_ff[k] && (!stage_v_ff[k+1] || move[k+1]);
      end
      req_ready = !stage_v_ff[0] || move[0];
      ld[0] = accept;
      for (int k = 1; k < STAGES; k++) begin
         ld[k] = move[k-1];
      end
   end

   assign en.ld_op   = ld[0];
   assign en.ld_diff = ld[1];
   assign en.ld_prod = ld[2];
   assign en.ld_flag = ld[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= ld | (stage_v_ff & ~move);
      end
   end

   assign meta_in.first = is_first;
   assign meta_in.last  = req_last_vertex;
   assign meta_in.use_a = !is_first;
   assign meta_in.use_b = req_last_vertex;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         meta_ff[0] <= meta_in;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ld[k]) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // edge from previous vertex to this one
   pip_edge_unit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_edge_a (
      .clock(clock),
      .en   (en),
      .ax   (prev_x_ff),
      .ay   (prev_y_ff),
      .bx   (req_vertex_x),
      .by   (req_vertex_y),
      .px   (qx_sel),
      .py   (qy_sel),
      .flags(flags_a)
   );

   // closing edge back to the first vertex
   pip_edge_unit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_edge_b (
      .clock(clock),
      .en   (en),
      .ax   (req_vertex_x),
      .ay   (req_vertex_y),
      .bx   (close_x),
      .by   (close_y),
      .px   (qx_sel),
      .py   (qy_sel),
      .flags(flags_b)
   );

   always_comb begin
      parity_base  = meta_ff[STAGES-1].first ? 1'b0 : parity_ff;
      on_edge_base = meta_ff[STAGES-1].first ? 1'b0 : on_edge_ff;
      parity_in    = parity_base
                   ^ (meta_ff[STAGES-1].use_a && flags_a.crossing)
                   ^ (meta_ff[STAGES-1].use_b && flags_b.crossing);
      on_edge_in   = on_edge_base
                   || (meta_ff[STAGES-1].use_a && flags_a.on_edge)
                   || (meta_ff[STAGES-1].use_b && flags_b.on_edge);
      if (on_edge_in) begin
         location_in = pip_pkg::LOC_BOUNDARY;
      end else if (parity_in) begin
         location_in = pip_pkg::LOC_INSIDE;
      end else begin
         location_in = pip_pkg::LOC_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff  <= 1'b0;
         on_edge_ff <= 1'b0;
      end else if (move[STAGES-1]) begin
         parity_ff  <= parity_in;
         on_edge_ff <= on_edge_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move[STAGES-1] && meta_ff[STAGES-1].last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move[STAGES-1] && meta_ff[STAGES-1].last) begin
         location_ff <= location_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_location = location_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(move[STAGES-1] && meta_ff[STAGES-1].last))
      else $error("response raised without a last vertex leaving the pipeline");

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_v_ff[0])
      else $error("request refused while first stage is empty");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(move[STAGES-1] && meta_ff[STAGES-1].last))
      else $error("pending response overwritten");

   a_close_polygon: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_vertex) |=> !in_polygon_ff)
      else $error("polygon still open after its last vertex");

endmodule

`default_nettype wire

>>> sv/pip_edge_unit.sv
`default_nettype none

module pip_edge_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire pip_pkg::stage_en_type         en,
   input  wire logic signed [COORD_WIDTH-1:0] ax,
   input  wire logic signed [COORD_WIDTH-1:0] ay,
   input  wire logic signed [COORD_WIDTH-1:0] bx,
   input  wire logic signed [COORD_WIDTH-1:0] by,
   input  wire logic signed [COORD_WIDTH-1:0] px,
   input  wire logic signed [COORD_WIDTH-1:0] py,
   output pip_pkg::edge_flags_type            flags
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   // stage 1: operands
   logic signed [COORD_WIDTH-1:0] ax_ff, ay_ff, bx_ff, by_ff, px_ff, py_ff;

   // stage 2: differences and y compares
   logic signed [DW-1:0] d1_ff, d2_ff, d3_ff, d4_ff, d5_ff, d6_ff, d7_ff, d8_ff;
   logic signed [DW-1:0] d1_in, d2_in, d3_in, d4_in, d5_in, d6_in, d7_in, d8_in;
   logic a_lt_b_ff, a_le_p_ff, b_gt_p_ff;

   // stage 3: products
   logic signed [PW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [PW-1:0] m1_in, m2_in, m3_in, m4_in;
   logic a_lt_b2_ff, a_le_p2_ff, b_gt_p2_ff;

   // stage 4: flags
   logic signed [SW-1:0] cross_in, dot_in;
   pip_pkg::edge_flags_type flags_ff, flags_in;

   always_ff @(posedge clock) begin
      if (en.ld_op) begin
         ax_ff <= ax;
         ay_ff <= ay;
         bx_ff <= bx;
         by_ff <= by;
         px_ff <= px;
         py_ff <= py;
      end
   end

   // cross(b - a, p - a) and dot(a - p, b - p)
   always_comb begin
      d1_in = DW'(bx_ff) - DW'(ax_ff);
      d2_in = DW'(py_ff) - DW'(ay_ff);
      d3_in = DW'(by_ff) - DW'(ay_ff);
      d4_in = DW'(px_ff) - DW'(ax_ff);
      d5_in = DW'(ax_ff) - DW'(px_ff);
      d6_in = DW'(bx_ff) - DW'(px_ff);
      d7_in = DW'(ay_ff) - DW'(py_ff);
      d8_in = DW'(by_ff) - DW'(py_ff);
   end

   always_ff @(posedge clock) begin
      if (en.ld_diff) begin
         d1_ff     <= d1_in;
         d2_ff     <= d2_in;
         d3_ff     <= d3_in;
         d4_ff     <= d4_in;
         d5_ff     <= d5_in;
         d6_ff     <= d6_in;
         d7_ff     <= d7_in;
         d8_ff     <= d8_in;
         a_lt_b_ff <= ay_ff < by_ff;
         a_le_p_ff <= ay_ff <= py_ff;
         b_gt_p_ff <= by_ff > py_ff;
      end
   end

   always_comb begin
      m1_in = d1_ff * d2_ff;
      m2_in = d3_ff * d4_ff;
      m3_in = d5_ff * d6_ff;
      m4_in = d7_ff * d8_ff;
   end

   always_ff @(posedge clock) begin
      if (en.ld_prod) begin
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         m3_ff      <= m3_in;
         m4_ff      <= m4_in;
         a_lt_b2_ff <= a_lt_b_ff;
         a_le_p2_ff <= a_le_p_ff;
         b_gt_p2_ff <= b_gt_p_ff;
      end
   end

   // downward edges are swapped before the half-open test, which flips the turn sign
   always_comb begin
      cross_in          = SW'(m1_ff) - SW'(m2_ff);
      dot_in            = SW'(m3_ff) + SW'(m4_ff);
      flags_in.on_edge  = (cross_in == '0) && (dot_in <= 0);
      flags_in.crossing = a_lt_b2_ff ? (a_le_p2_ff && b_gt_p2_ff && (cross_in > 0))
                                     : (!b_gt_p2_ff && !a_le_p2_ff && (cross_in < 0));
   end

   always_ff @(posedge clock) begin
      if (en.ld_flag) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W      = 16;
   localparam int RANDOM_ITEMS = 550;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 250000;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_vertex_x    = '0;
   logic signed [COORD_W-1:0] req_vertex_y    = '0;
   logic signed [COORD_W-1:0] req_point_x     = '0;
   logic signed [COORD_W-1:0] req_point_y     = '0;
   logic                      req_last_vertex = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic [1:0]                rsp_location;

   point_in_polygon_test_core #(
      .COORD_WIDTH(COORD_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vertex_x   (req_vertex_x),
      .req_vertex_y   (req_vertex_y),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_location   (rsp_location)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic signed [COORD_W-1:0] start_x, start_y, tail_x, tail_y, probe_x, probe_y;
   bit                        polygon_open;
   bit                        odd_crossings;
   bit                        boundary_hit;

   pip_pkg::location_type expected_loc_q[$];
   int           fail_count  = 0;
   int           cycle_count = 0;
   bit           idle_on     = 1'b1;
   int           poly_x[$];
   int           poly_y[$];

   function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                 longint qx, longint qy);
      longint c;
      c = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
      return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
   endfunction

   function automatic void scan_edge(longint ax, longint ay, longint bx, longint by);
      longint px, py, dot, t;
      px  = probe_x;
      py  = probe_y;
      dot = (ax - px) * (bx - px) + (ay - py) * (by - py);
      if (orient(ax, ay, bx, by, px, py) == 0 && dot <= 0) begin
         boundary_hit = 1'b1;
      end
      // orient upward so the crossing rule is half-open at the lower end
      if (!(ay < by)) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      if (ay <= py && by > py && orient(ax, ay, bx, by, px, py) > 0) begin
         odd_crossings = ~odd_crossings;
      end
   endfunction

   function automatic void predict_vertex(logic signed [COORD_W-1:0] vx,
                                          logic signed [COORD_W-1:0] vy,
                                          logic signed [COORD_W-1:0] px,
                                          logic signed [COORD_W-1:0] py,
                                          logic last);
      if (!polygon_open) begin
         probe_x       = px;
         probe_y       = py;
         start_x       = vx;
         start_y       = vy;
         odd_crossings = 1'b0;
         boundary_hit  = 1'b0;
         polygon_open  = 1'b1;
      end else begin
         scan_edge(tail_x, tail_y, vx, vy);
      end
      tail_x = vx;
      tail_y = vy;
      if (last) begin
         scan_edge(vx, vy, start_x, start_y);
         if (boundary_hit) expected_loc_q = {expected_loc_q, pip_pkg::LOC_BOUNDARY};
         else if (odd_crossings) expected_loc_q = {expected_loc_q, pip_pkg::LOC_INSIDE};
         else expected_loc_q = {expected_loc_q, pip_pkg::LOC_OUTSIDE};
         polygon_open = 1'b0;
      end
   endfunction

   task automatic send_vertex(input int vx, input int vy, input int px, input int py,
                              input bit last);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= COORD_W'(vx);
      req_vertex_y    <= COORD_W'(vy);
      req_point_x     <= COORD_W'(px);
      req_point_y     <= COORD_W'(py);
      req_last_vertex <= last;
      do @(posedge clock); while (!req_ready);
      predict_vertex(COORD_W'(vx), COORD_W'(vy), COORD_W'(px), COORD_W'(py), last);
   endtask

   // the query point only counts at the first vertex; later ones carry junk
   task automatic send_polygon(input int px, input int py);
      for (int i = 0; i < poly_x.size(); i++) begin
         if (i == 0) begin
            send_vertex(poly_x[i], poly_y[i], px, py, poly_x.size() == 1);
         end else begin
            send_vertex(poly_x[i], poly_y[i], $signed(16'($urandom)),
                        $signed(16'($urandom)), i == poly_x.size() - 1);
         end
      end
   endtask

   function automatic int rand_coord(int scale);
      int span;
      if (scale >= 2) return $signed(16'($urandom));
      span = (scale == 0) ? 8 : 1000;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic test_single_vertex();
      poly_x = '{-32768};
      poly_y = '{32767};
      send_polygon(-32768, 32767);
      poly_x = '{5};
      poly_y = '{-3};
      send_polygon(5, -2);
   endtask

   task automatic test_two_vertex();
      poly_x = '{-10, 10};
      poly_y = '{-6, 6};
      send_polygon(5, 3);
      poly_x = '{-10, 10};
      poly_y = '{-6, 6};
      send_polygon(20, 12);
   endtask

   task automatic test_triangle();
      poly_x = '{0, 20, 10};
      poly_y = '{0, 0, 20};
      send_polygon(10, 5);
      // point on the horizontal base
      poly_x = '{0, 20, 10};
      poly_y = '{0, 0, 20};
      send_polygon(7, 0);
      // ray passes exactly through the apex
      poly_x = '{0, 20, 10};
      poly_y = '{0, 0, 20};
      send_polygon(-5, 20);
   endtask

   task automatic test_extremes();
      poly_x = '{-32768, 32767, 0};
      poly_y = '{-32768, -32768, 32767};
      send_polygon(0, 0);
   endtask

   task automatic test_self_crossing();
      poly_x = '{0, 10, 10, 0};
      poly_y = '{0, 10, 0, 10};
      send_polygon(2, 5);
   endtask

   task automatic test_random_polygons();
      int sent, n, scale, pick, k, px, py;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) idle_on = ~idle_on;
         pick = $urandom_range(0, 19);
         n = (pick == 0) ? 1 : (pick == 1) ? 2 :
             (pick == 2) ? $urandom_range(9, 20) : $urandom_range(3, 8);
         scale = $urandom_range(0, 2);
         poly_x.delete();
         poly_y.delete();
         for (int i = 0; i < n; i++) begin
            poly_x = {poly_x, rand_coord(scale)};
            poly_y = {poly_y, rand_coord(scale)};
         end
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 4))
            0: begin
               px = poly_x[k];
               py = poly_y[k];
            end
            1: begin
               px = (poly_x[k] + poly_x[(k + 1) % n]) >>> 1;
               py = (poly_y[k] + poly_y[(k + 1) % n]) >>> 1;
            end
            2: begin
               px = rand_coord(scale);
               py = poly_y[k];
            end
            default: begin
               px = rand_coord(scale);
               py = rand_coord(scale);
            end
         endcase
         send_polygon(px, py);
         sent += n;
      end
      idle_on = 1'b1;
   endtask

   // response side: random stall per request, then compare
   initial begin : rsp_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 17) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_loc_q.size() == 0) begin
            $error("location: no request pending, got %0d", rsp_location);
            fail_count++;
         end else begin
            pip_pkg::location_type want;
            want = expected_loc_q.pop_front();
            if (rsp_location !== want) begin
               $error("location: expected %0d, got %0d", want, rsp_location);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("point_in_polygon_test_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_vertex();
      test_two_vertex();
      test_triangle();
      test_extremes();
      test_self_crossing();
      test_random_polygons();
      req_valid <= 1'b0;
      while (expected_loc_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("point_in_polygon_test_core: match");
      end else begin
         $display("point_in_polygon_test_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
